// ===== sv/magnetorquer_pwm_command_core_defines.svh =====
// Assertion macros shared by the magnetorquer PWM command RTL.
`ifndef MAGNETORQUER_PWM_COMMAND_CORE_DEFINES_SVH
`define MAGNETORQUER_PWM_COMMAND_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk and held off during reset.
`define MPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and held off during reset.
`define MPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mpc_pkg.sv =====
// Shared types and constants for the magnetorquer PWM command block.
package mpc_pkg;

    // Field widths.
    localparam int MOM_W  = 16;
    localparam int LIM_W  = 15;
    localparam int ABS_W  = MOM_W + 1;
    localparam int CH_W   = 4;
    localparam int ON_W   = 12;

    // Duty scaling and the serial divider sized from it.
    localparam int PWM_FULL_SCALE = 4095;
    localparam int QUOT_W = $clog2(PWM_FULL_SCALE + 1);
    localparam int NUM_W  = LIM_W + QUOT_W;
    localparam int CNT_W  = $clog2(QUOT_W);

    // Channel sequencing.
    localparam int NUM_CHANNELS = 10;
    localparam logic [CH_W-1:0] LAST_CHAN = CH_W'(NUM_CHANNELS - 1);

    // Configuration registers.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_XY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Z  = 1'b1;
    localparam logic [LIM_W-1:0] LIM_XY_RESET = 15'd14287;
    localparam logic [LIM_W-1:0] LIM_Z_RESET  = 15'd7143;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_TEST,
        ST_DIV,
        ST_EMIT,
        ST_REJ
    } state_t;

    // Control and status between the sequencer and a divider lane.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/mpc_div.sv =====
// Bit-serial restoring divider: floor(diff * PWM_FULL_SCALE / den), one bit per cycle.
module mpc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mpc_pkg::div_ctrl_t        ctrl,
    input  logic [mpc_pkg::LIM_W-1:0] diff,
    input  logic [mpc_pkg::LIM_W-1:0] den,
    output mpc_pkg::div_stat_t        stat,
    output logic [mpc_pkg::QUOT_W-1:0] quot
);
    import mpc_pkg::*;

    logic [LIM_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0] num_reg, num_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [LIM_W-1:0]  den_reg, den_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [NUM_W-1:0]  prod;
    logic [LIM_W:0]    trial;
    logic [LIM_W-1:0]  trial_sub;
    logic              ge;

    // Scaled numerator; the high part seeds the remainder, the low part shifts in.
    assign prod      = NUM_W'(diff) * NUM_W'(PWM_FULL_SCALE);
    assign trial     = {rem_reg, num_reg[QUOT_W-1]};
    assign ge        = trial >= {1'b0, den_reg};
    // The remainder stays below the divisor, so the low bits of the difference suffice.
    assign trial_sub = trial[LIM_W-1:0] - den_reg;

    // One quotient bit per cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            rem_next  = prod[NUM_W-1:QUOT_W];
            num_next  = prod[QUOT_W-1:0];
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? trial_sub : trial[LIM_W-1:0];
            num_next  = {num_reg[QUOT_W-2:0], 1'b0};
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

// ===== sv/magnetorquer_pwm_command_core.sv =====
// Top level of the magnetorquer PWM command block: limit check, duty divide, channel output.
// A request on s_axis is checked against the X/Y and Z limits. A rejected request gives one
// result with the rejected and error flags set, loaded once the output register is free, and
// the next request can be taken after that result has entered the output register. An
// accepted request runs its three axis duties through three parallel bit-serial dividers,
// one quotient bit per cycle, then sends ten channel transactions, one per cycle while m_axis
// is ready; the serial divide and the one-channel-per-cycle output set how long a request
// occupies the block. The next request is taken once the last channel has entered the output
// register, even if that result still waits on m_axis.
`include "magnetorquer_pwm_command_core_defines.svh"

module magnetorquer_pwm_command_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [47:0]                   s_axis_tdata,   // moment_x, moment_y, moment_z
    // Channel setting stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // channel, on_count
    output logic [2:0]                    m_axis_tuser,   // full_off, rejected, error_seen
    output logic                          m_axis_tlast,
    // Configuration writes.
    input  logic                          cfg_we,
    input  logic [mpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mpc_pkg::LIM_W-1:0]     cfg_data
);
    import mpc_pkg::*;

    state_t state_reg, state_next;

    logic [LIM_W-1:0]  lim_xy_reg, lim_z_reg;
    logic              error_sticky_reg;
    logic [MOM_W-1:0]  mom_x_reg, mom_y_reg, mom_z_reg;
    logic [ABS_W-1:0]  abs_x_reg, abs_y_reg, abs_z_reg;
    logic [CH_W-1:0]   chan_cnt_reg, chan_cnt_next;

    logic              out_valid_reg, out_valid_next;
    logic [CH_W-1:0]   out_chan_reg;
    logic [ON_W-1:0]   out_on_reg;
    logic              out_off_reg, out_rej_reg, out_err_reg, out_last_reg;

    logic              in_fire, out_free, reject;
    logic              emit_load, rej_load, set_error, div_start;
    div_ctrl_t         div_ctrl;
    div_stat_t         stat_x, stat_y, stat_z;
    logic [QUOT_W-1:0] quot_x, quot_y, quot_z;
    logic [LIM_W-1:0]  diff_x, diff_y, diff_z;

    logic              sel_sign, sel_nz, drives, second_pair;
    logic [ON_W-1:0]   sel_duty;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Limit check on the registered magnitudes.
    assign reject = (abs_x_reg > ABS_W'(lim_xy_reg)) || (abs_y_reg > ABS_W'(lim_xy_reg))
                 || (abs_z_reg > ABS_W'(lim_z_reg));

    assign diff_x = lim_xy_reg - abs_x_reg[LIM_W-1:0];
    assign diff_y = lim_xy_reg - abs_y_reg[LIM_W-1:0];
    assign diff_z = lim_z_reg  - abs_z_reg[LIM_W-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = ST_MAG;
            ST_MAG:  state_next = ST_TEST;
            ST_TEST: state_next = reject ? ST_REJ : ST_DIV;
            ST_DIV:  if (stat_x.done) state_next = ST_EMIT;
            ST_EMIT: if (out_free && chan_cnt_reg == LAST_CHAN) state_next = ST_IDLE;
            ST_REJ:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        set_error     = 1'b0;
        emit_load     = 1'b0;
        rej_load      = 1'b0;
        case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_TEST:
            begin
                div_start = !reject;
                set_error = reject;
            end
            ST_EMIT: emit_load = out_free;
            ST_REJ:  rej_load  = out_free;
            default: ;
        endcase
    end

    assign div_ctrl.start = div_start;

    // Three divider lanes, one per axis.
    mpc_div u_div_x (
        .clk(clk), .rst_n(rst_n), .ctrl(div_ctrl), .diff(diff_x), .den(lim_xy_reg),
        .stat(stat_x), .quot(quot_x)
    );
    mpc_div u_div_y (
        .clk(clk), .rst_n(rst_n), .ctrl(div_ctrl), .diff(diff_y), .den(lim_xy_reg),
        .stat(stat_y), .quot(quot_y)
    );
    mpc_div u_div_z (
        .clk(clk), .rst_n(rst_n), .ctrl(div_ctrl), .diff(diff_z), .den(lim_z_reg),
        .stat(stat_z), .quot(quot_z)
    );

    // Pick the axis of the current channel and decide whether it carries the duty.
    always_comb
    begin
        if (chan_cnt_reg[3])
        begin
            sel_sign = mom_z_reg[MOM_W-1];
            sel_nz   = |abs_z_reg;
            sel_duty = ON_W'(quot_z);
        end
        else if (chan_cnt_reg[2])
        begin
            sel_sign = mom_y_reg[MOM_W-1];
            sel_nz   = |abs_y_reg;
            sel_duty = ON_W'(quot_y);
        end
        else
        begin
            sel_sign = mom_x_reg[MOM_W-1];
            sel_nz   = |abs_x_reg;
            sel_duty = ON_W'(quot_x);
        end
        // The second pair of a bridge swaps the roles of pos and neg.
        second_pair = chan_cnt_reg[1] && !chan_cnt_reg[3];
        drives = (chan_cnt_reg[0] ^ second_pair) ? sel_sign : (!sel_sign && sel_nz);
    end

    assign chan_cnt_next = emit_load ? ((chan_cnt_reg == LAST_CHAN) ? '0 : chan_cnt_reg + 1'b1)
                                     : chan_cnt_reg;

    assign out_valid_next = (emit_load || rej_load) ? 1'b1
                          : (m_axis_tready ? 1'b0 : out_valid_reg);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            lim_xy_reg       <= LIM_XY_RESET;
            lim_z_reg        <= LIM_Z_RESET;
            error_sticky_reg <= 1'b0;
            chan_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_cnt_reg  <= chan_cnt_next;
            out_valid_reg <= out_valid_next;
            if (set_error)
            begin
                error_sticky_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_XY: lim_xy_reg <= cfg_data;
                    REG_MAX_Z:  lim_z_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Request capture and magnitudes.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mom_x_reg <= s_axis_tdata[15:0];
            mom_y_reg <= s_axis_tdata[31:16];
            mom_z_reg <= s_axis_tdata[47:32];
        end
        if (state_reg == ST_MAG)
        begin
            abs_x_reg <= mom_x_reg[MOM_W-1] ? -{1'b1, mom_x_reg} : {1'b0, mom_x_reg};
            abs_y_reg <= mom_y_reg[MOM_W-1] ? -{1'b1, mom_y_reg} : {1'b0, mom_y_reg};
            abs_z_reg <= mom_z_reg[MOM_W-1] ? -{1'b1, mom_z_reg} : {1'b0, mom_z_reg};
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_chan_reg <= chan_cnt_reg;
            out_on_reg   <= drives ? sel_duty : '0;
            out_off_reg  <= !drives;
            out_rej_reg  <= 1'b0;
            out_err_reg  <= error_sticky_reg;
            out_last_reg <= (chan_cnt_reg == LAST_CHAN);
        end
        else if (rej_load)
        begin
            out_chan_reg <= '0;
            out_on_reg   <= '0;
            out_off_reg  <= 1'b0;
            out_rej_reg  <= 1'b1;
            out_err_reg  <= 1'b1;
            out_last_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_on_reg, out_chan_reg};
    assign m_axis_tuser  = {out_err_reg, out_rej_reg, out_off_reg};
    assign m_axis_tlast  = out_last_reg;

    // The three divider lanes run in lockstep.
    `MPC_ASSERT_NOW(a_lanes_lockstep, 1'b1, (stat_y == stat_x) && (stat_z == stat_x),
        "divider lanes out of step")
    // Waiting for a quotient means a divider is running or just finished.
    `MPC_ASSERT_NOW(a_div_running, state_reg == ST_DIV, stat_x.busy || stat_x.done,
        "waiting on an idle divider")
    // The error flag never clears once set.
    `MPC_ASSERT_NEXT(a_error_sticky, error_sticky_reg, error_sticky_reg,
        "sticky error flag cleared")

endmodule

// ===== tb/magnetorquer_pwm_command_core_test.sv =====
// Self-checking testbench for the magnetorquer PWM command core with its own duty predictor.
module magnetorquer_pwm_command_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mpc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 40;

    // One channel setting as it leaves the block.
    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic [ON_W-1:0] on_count;
        logic            full_off;
        logic            rejected;
        logic            error_seen;
        logic            last;
    } chan_setting_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;
    logic [2:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_XY;
    logic [LIM_W-1:0]     cfg_data = '0;

    // Requests waiting to be sent, packed as {moment_z, moment_y, moment_x}.
    logic [47:0]          pending_requests[$];
    chan_setting_t        expected_settings[$];

    // Predictor copy of the limits and the sticky error flag.
    int unsigned          lim_xy = LIM_XY_RESET;
    int unsigned          lim_z = LIM_Z_RESET;
    logic                 model_error_seen = 1'b0;

    logic                 calm = 1'b0;
    int                   gap_left = 0;
    int                   stall_left = 0;
    int                   failures = 0;
    int                   cycles = 0;

    magnetorquer_pwm_command_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected settings of one axis: two bridge pairs for X and Y, one pair for Z.
    function automatic void add_axis_settings(int unsigned base, int pairs,
                                              logic signed [MOM_W-1:0] m, int unsigned lim);
        int unsigned   a;
        int unsigned   duty;
        logic          pos_drives;
        logic          neg_drives;
        chan_setting_t s;
        a = (m < 0) ? int'(-int'(m)) : int'(m);
        duty = (m != 0) ? (int'(PWM_FULL_SCALE) * (lim - a)) / lim : 0;
        for (int p = 0; p < pairs; p++)
        begin
            // The second pair of a bridge drives the opposite way.
            pos_drives = (p == 0) ? (m > 0) : (m < 0);
            neg_drives = (p == 0) ? (m < 0) : (m > 0);
            s.rejected = 1'b0;
            s.error_seen = model_error_seen;
            s.channel = CH_W'(base + 2 * p);
            s.on_count = pos_drives ? ON_W'(duty) : '0;
            s.full_off = !pos_drives;
            s.last = 1'b0;
            expected_settings.push_back(s);
            s.channel = CH_W'(base + 2 * p + 1);
            s.on_count = neg_drives ? ON_W'(duty) : '0;
            s.full_off = !neg_drives;
            s.last = (s.channel == LAST_CHAN);
            expected_settings.push_back(s);
        end
    endfunction

    // Limit check, then either one rejection or the ten channel settings.
    function automatic void predict_channel_settings(logic [47:0] req);
        logic signed [MOM_W-1:0] mx;
        logic signed [MOM_W-1:0] my;
        logic signed [MOM_W-1:0] mz;
        int unsigned             ax;
        int unsigned             ay;
        int unsigned             az;
        chan_setting_t           s;
        mx = req[15:0];
        my = req[31:16];
        mz = req[47:32];
        ax = (mx < 0) ? int'(-int'(mx)) : int'(mx);
        ay = (my < 0) ? int'(-int'(my)) : int'(my);
        az = (mz < 0) ? int'(-int'(mz)) : int'(mz);
        if (ax > lim_xy || ay > lim_xy || az > lim_z)
        begin
            model_error_seen = 1'b1;
            s = '0;
            s.rejected = 1'b1;
            s.error_seen = 1'b1;
            s.last = 1'b1;
            expected_settings.push_back(s);
        end
        else
        begin
            add_axis_settings(0, 2, mx, lim_xy);
            add_axis_settings(4, 2, my, lim_xy);
            add_axis_settings(8, 1, mz, lim_z);
        end
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    // Random moment for one axis, mostly within the limit, some at or just past it, some anywhere in range.
    function automatic logic [MOM_W-1:0] random_moment(int unsigned lim);
        int unsigned             pick;
        int unsigned             mag;
        logic signed [MOM_W-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            mag = $urandom_range(0, lim);
        else if (pick < 72)
            mag = lim;
        else if (pick < 80)
            mag = 0;
        else if (pick < 86 && lim < 32767)
            mag = lim + 1;
        else
            return MOM_W'($urandom());
        v = MOM_W'(mag);
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    task automatic send(int x, int y, int z);
        pending_requests.push_back({MOM_W'(z), MOM_W'(y), MOM_W'(x)});
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
            pending_requests.push_back({random_moment(lim_z), random_moment(lim_xy),
                                        random_moment(lim_xy)});
    endtask

    // Wait until every request is taken and every setting has come back.
    // Sampled mid-cycle so that the driver and monitor updates of the last edge are settled.
    task automatic drain();
        @(negedge clk);
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_settings.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= LIM_W'(val);
        if (idx == REG_MAX_XY)
            lim_xy = val & 32'h7FFF;
        else
            lim_z = val & 32'h7FFF;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Request driver: predicts each accepted transaction, then loads the next one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_channel_settings(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_requests.size() == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 3) == 0)
                begin
                    gap_left = $urandom_range(1, 19) - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    s_axis_tdata <= pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // Result monitor: checks each channel transaction against the oldest expectation.
    always @(posedge clk)
    begin
        chan_setting_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_settings.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, actual tdata %h tuser %b",
                             $time, m_axis_tdata, m_axis_tuser);
                    failures++;
                end
                else
                begin
                    want = expected_settings.pop_front();
                    compare_field("channel", want.channel, m_axis_tdata[3:0]);
                    compare_field("on_count", want.on_count, m_axis_tdata[15:4]);
                    compare_field("full_off", want.full_off, m_axis_tuser[0]);
                    compare_field("rejected", want.rejected, m_axis_tuser[1]);
                    compare_field("error_seen", want.error_seen, m_axis_tuser[2]);
                    compare_field("last", want.last, m_axis_tlast);
                end
            end
            // Back-pressure in random bursts.
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset limits: zero request, exact limits, smallest magnitudes, each rejection.
        send(0, 0, 0);
        send(14287, -14287, 7143);
        send(-14287, 14287, -7143);
        send(1, -1, 1);
        send(100, -200, 300);
        send(-5000, 0, 2000);
        send(0, 7000, 0);
        send(14288, 0, 0);
        send(0, -14288, 0);
        send(0, 0, 7144);
        send(-32768, 0, 0);
        send(0, 0, -32768);
        send(32767, 32767, 32767);
        send(-1, 1, -1);
        send_random(60);
        drain();

        // Widest limits, including the most negative input.
        write_limit(REG_MAX_XY, 32767);
        write_limit(REG_MAX_Z, 32767);
        send(32767, -32767, 32767);
        send(-32767, 32767, -32767);
        send(21845, -10922, 1);
        send(0, -32768, 0);
        send_random(50);
        drain();

        // Narrowest limits.
        write_limit(REG_MAX_XY, 1);
        write_limit(REG_MAX_Z, 1);
        send(1, -1, 0);
        send(0, 0, -1);
        send(2, 0, 0);
        send_random(30);
        drain();

        // Zero limits: only all-zero requests get through.
        write_limit(REG_MAX_XY, 0);
        write_limit(REG_MAX_Z, 0);
        send(0, 0, 0);
        send(1, 0, 0);
        send(0, 0, -1);
        send_random(15);
        drain();

        // Random limits within range.
        write_limit(REG_MAX_XY, $urandom_range(1, 32767));
        write_limit(REG_MAX_Z, $urandom_range(1, 32767));
        send_random(60);
        drain();

        // Final stretch at full rate on both sides.
        write_limit(REG_MAX_XY, $urandom_range(1, 32767));
        write_limit(REG_MAX_Z, $urandom_range(1, 300));
        calm = 1'b1;
        send_random(40);
        drain();

        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/mpc_pkg.sv
sv/mpc_div.sv
sv/magnetorquer_pwm_command_core.sv
tb/magnetorquer_pwm_command_core_test.sv
